// File: sv/cgrd_pkg.sv
// ============================================================================
// cgrd_pkg
// Shared types and constants for the character grid rectangle drawer.
// ============================================================================
package cgrd_pkg;

  localparam int DEF_GRID_ROWS = 32;
  localparam int DEF_GRID_COLS = 128;

  localparam logic [7:0] SYM_LOW     = 8'd33;
  localparam logic [7:0] SYM_HIGH    = 8'd126;
  localparam logic [7:0] EMPTY_RESET = 8'd32;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_DRAW  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_COORD  = 2'd1;
  localparam logic [1:0] ST_SYMBOL = 2'd2;
  localparam logic [1:0] ST_ORDER  = 2'd3;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [7:0] cell_value;
  } cgrd_res_t;

endpackage

// File: sv/cgrd_mem.sv
// ============================================================================
// cgrd_mem
// Single-port cell store with registered read data.
// ============================================================================
module cgrd_mem #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [2**AW];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/cgrd_ctrl.sv
// ============================================================================
// cgrd_ctrl
// Command sequencer: checks, clearing sweep and perimeter walk over the store.
// ============================================================================
module cgrd_ctrl import cgrd_pkg::*; #(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS,
  parameter int ROW_AW    = 5,
  parameter int COL_AW    = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cmd_valid,
  output logic                     cmd_stall,
  input  logic [1:0]               cmd_operation,
  input  logic [7:0]               cmd_row,
  input  logic [7:0]               cmd_col,
  input  logic [7:0]               cmd_row_end,
  input  logic [7:0]               cmd_col_end,
  input  logic [7:0]               cmd_symbol,
  input  logic [7:0]               empty_symbol,
  output logic                     mem_we,
  output logic [ROW_AW+COL_AW-1:0] mem_addr,
  output logic [7:0]               mem_wdata,
  input  logic [7:0]               mem_rdata,
  output cgrd_res_t                res,
  input  logic                     res_take
);

  localparam int AW = ROW_AW + COL_AW;
  localparam logic [7:0] ROWS8 = 8'(GRID_ROWS);
  localparam logic [7:0] COLS8 = 8'(GRID_COLS);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_RDWAIT, S_HORIZ, S_VERT, S_FINISH
  } state_t;

  state_t       state_r, state_nxt;
  logic [1:0]   op_r, op_nxt;
  logic [7:0]   r_r, r_nxt, c_r, c_nxt, r2_r, r2_nxt, c2_r, c2_nxt, sym_r, sym_nxt;
  logic [7:0]   idx_r, idx_nxt;
  logic         side_r, side_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [1:0]   status_r, status_nxt;
  logic [7:0]   value_r, value_nxt;
  logic [1:0]   chk_status;

  function automatic logic in_grid(input logic [7:0] rw, input logic [7:0] cl);
    return (rw != 8'd0) && (rw <= ROWS8) && (cl != 8'd0) && (cl <= COLS8);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [7:0] rw, input logic [7:0] cl);
    logic [7:0] rm;
    logic [7:0] cm;
    rm = rw - 8'd1;
    cm = cl - 8'd1;
    return {rm[ROW_AW-1:0], cm[COL_AW-1:0]};
  endfunction

  // Checks in order: coordinates, corner order, symbol.
  always_comb begin
    logic ok1;
    logic ok2;
    logic vis;
    ok1 = in_grid(r_r, c_r);
    ok2 = in_grid(r2_r, c2_r);
    vis = (sym_r >= SYM_LOW) && (sym_r <= SYM_HIGH);
    chk_status = ST_OK;
    unique case (op_r)
      OP_PUT: begin
        if (!ok1) chk_status = ST_COORD;
        else if (!vis) chk_status = ST_SYMBOL;
      end
      OP_DRAW: begin
        if (!(ok1 && ok2)) chk_status = ST_COORD;
        else if ((r_r > r2_r) || (c_r > c2_r)) chk_status = ST_ORDER;
        else if (!vis) chk_status = ST_SYMBOL;
      end
      default: begin
        if (!ok1) chk_status = ST_COORD;
      end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    r_nxt      = r_r;
    c_nxt      = c_r;
    r2_nxt     = r2_r;
    c2_nxt     = c2_r;
    sym_nxt    = sym_r;
    idx_nxt    = idx_r;
    side_nxt   = side_r;
    clr_nxt    = clr_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    mem_we     = 1'b0;
    mem_addr   = cell_addr(r_r, c_r);
    mem_wdata  = sym_r;
    cmd_stall  = (state_r != S_IDLE);
    res.valid      = (state_r == S_FINISH);
    res.status     = status_r;
    res.cell_value = value_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = EMPTY_RESET;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          op_nxt    = cmd_operation;
          r_nxt     = cmd_row;
          c_nxt     = cmd_col;
          r2_nxt    = cmd_row_end;
          c2_nxt    = cmd_col_end;
          sym_nxt   = cmd_symbol;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        status_nxt = chk_status;
        value_nxt  = 8'd0;
        idx_nxt    = c_r;
        side_nxt   = 1'b0;
        state_nxt  = S_FINISH;
        if (chk_status == ST_OK) begin
          unique case (op_r)
            OP_PUT:   mem_we = 1'b1;
            OP_ERASE: begin
              mem_we    = 1'b1;
              mem_wdata = empty_symbol;
            end
            OP_DRAW:  state_nxt = S_HORIZ;
            default:  state_nxt = S_RDWAIT;
          endcase
        end
      end
      S_RDWAIT: begin
        value_nxt = mem_rdata;
        state_nxt = S_FINISH;
      end
      S_HORIZ: begin
        // Top and bottom edges, alternating one cell of each per cycle.
        mem_we   = 1'b1;
        mem_addr = cell_addr(side_r ? r2_r : r_r, idx_r);
        side_nxt = ~side_r;
        if (side_r) begin
          if (idx_r == c2_r) begin
            idx_nxt   = r_r;
            state_nxt = S_VERT;
          end else begin
            idx_nxt = idx_r + 8'd1;
          end
        end
      end
      S_VERT: begin
        // Left and right edges, alternating in the same way.
        mem_we   = 1'b1;
        mem_addr = cell_addr(idx_r, side_r ? c2_r : c_r);
        side_nxt = ~side_r;
        if (side_r) begin
          if (idx_r == r2_r) state_nxt = S_FINISH;
          else idx_nxt = idx_r + 8'd1;
        end
      end
      S_FINISH: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    op_r     <= op_nxt;
    r_r      <= r_nxt;
    c_r      <= c_nxt;
    r2_r     <= r2_nxt;
    c2_r     <= c2_nxt;
    sym_r    <= sym_nxt;
    idx_r    <= idx_nxt;
    side_r   <= side_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
  end

endmodule

// File: sv/char_grid_rectangle_drawer.sv
// ============================================================================
// char_grid_rectangle_drawer
// Character grid store taking put, erase, rectangle outline and read commands.
// ============================================================================
// Put, erase and failed commands pass the check and finish states on their way
// to the result register; a read adds a wait state for the registered store data,
// and a rectangle walks the perimeter, one cell per cycle through the single port.
// One item is worked at a time; the next is taken once the result is handed off.
// After reset a clearing sweep writes 2**(row bits + column bits) cells
// (4096 at the default size) before the first item is taken.
module char_grid_rectangle_drawer import cgrd_pkg::*; #(
  parameter int GRID_ROWS = DEF_GRID_ROWS,
  parameter int GRID_COLS = DEF_GRID_COLS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_row,
  input  logic [7:0] in_col,
  input  logic [7:0] in_row_end,
  input  logic [7:0] in_col_end,
  input  logic [7:0] in_symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_cell_value,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  // The store is addressed as {row - 1, column - 1}, so each coordinate gets
  // just enough bits for its range and unused column slots cost nothing in logic.
  localparam int ROW_AW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int COL_AW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int AW     = ROW_AW + COL_AW;

  logic [7:0]    empty_symbol_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [7:0]    out_cell_value_r;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;
  cgrd_res_t     res;
  logic          res_take;

  // The output register is free when empty or when its item leaves this cycle.
  assign res_take = !out_valid_r || !out_stall;

  cgrd_ctrl #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .ROW_AW    (ROW_AW),
    .COL_AW    (COL_AW)
  ) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (in_valid),
    .cmd_stall     (in_stall),
    .cmd_operation (in_operation),
    .cmd_row       (in_row),
    .cmd_col       (in_col),
    .cmd_row_end   (in_row_end),
    .cmd_col_end   (in_col_end),
    .cmd_symbol    (in_symbol),
    .empty_symbol  (empty_symbol_r),
    .mem_we        (mem_we),
    .mem_addr      (mem_addr),
    .mem_wdata     (mem_wdata),
    .mem_rdata     (mem_rdata),
    .res           (res),
    .res_take      (res_take)
  );

  cgrd_mem #(
    .AW (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // The empty symbol register only affects later erases; the clearing sweep
  // always uses the reset value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_symbol_r <= EMPTY_RESET;
    end else if (cfg_we) begin
      empty_symbol_r <= cfg_wdata;
    end
  end

  // Result register decouples the sequencer from the downstream stall.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res.valid && res_take) begin
      out_status_r     <= res.status;
      out_cell_value_r <= res.cell_value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_cell_value = out_cell_value_r;

endmodule

// File: tb/sv/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for char_grid_rectangle_drawer
// Sends put, erase, rectangle and read commands with random gaps and output
// stalls, predicts every status and cell value from a shadow copy of the grid,
// and checks each result in order as it leaves the block.
// ============================================================================
module tb_top;
  import cgrd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = DEF_GRID_ROWS;
  localparam int COLS = DEF_GRID_COLS;

  // The longest correct wait without any handshake is the clearing sweep after
  // reset; a full-grid outline, plus a long output stall and a long input gap,
  // is shorter. The limit is several times the worst case.
  localparam int IDLE_LIMIT   = 20000;
  // Cycles allowed after the last result for anything unexpected to show up.
  localparam int DRAIN_CYCLES = 400;

  // One command as seen on the input channel.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] row_end;
    logic [7:0] col_end;
    logic [7:0] symbol;
  } grid_cmd_t;

  // One answer as seen on the result channel.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] cell_value;
  } grid_answer_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] in_operation;
  logic [7:0] in_row;
  logic [7:0] in_col;
  logic [7:0] in_row_end;
  logic [7:0] in_col_end;
  logic [7:0] in_symbol;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_cell_value;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  // Shadow copy of the grid and of the blank symbol used by erase.
  logic [7:0]   shadow_grid [ROWS*COLS];
  logic [7:0]   shadow_blank;
  // Answers predicted for accepted commands, oldest first.
  grid_answer_t answers_q[$];

  int error_count = 0;
  int idle_cycles = 0;
  // When set, neither side inserts gaps or stalls.
  bit calm = 1'b0;
  int stall_left = 0;

  char_grid_rectangle_drawer u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_row_end     (in_row_end),
    .in_col_end     (in_col_end),
    .in_symbol      (in_symbol),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_cell_value (out_cell_value),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Grid predictor
  // ---------------------------------------------------------------------------

  // A coordinate pair is on the grid when both parts are one-based and in range;
  // zero is always off the grid.
  function automatic bit on_grid(logic [7:0] r, logic [7:0] c);
    return r >= 8'd1 && r <= ROWS && c >= 8'd1 && c <= COLS;
  endfunction

  // Only printable, non-space ASCII may be written by put and draw.
  function automatic bit printable(logic [7:0] s);
    return s >= SYM_LOW && s <= SYM_HIGH;
  endfunction

  function automatic int cell_index(int r, int c);
    return (r - 1) * COLS + (c - 1);
  endfunction

  // Applies one command to the shadow grid and returns the answer the block
  // must give. Checks go coordinates first, then corner order, then symbol.
  function automatic grid_answer_t apply_cmd(grid_cmd_t c);
    grid_answer_t a;
    int i;
    a.status = ST_OK;
    a.cell_value = 8'd0;
    case (c.op)
      OP_PUT: begin
        if (!on_grid(c.row, c.col)) begin
          a.status = ST_COORD;
        end else if (!printable(c.symbol)) begin
          a.status = ST_SYMBOL;
        end else begin
          shadow_grid[cell_index(c.row, c.col)] = c.symbol;
        end
      end
      OP_ERASE: begin
        if (!on_grid(c.row, c.col)) begin
          a.status = ST_COORD;
        end else begin
          shadow_grid[cell_index(c.row, c.col)] = shadow_blank;
        end
      end
      OP_DRAW: begin
        if (!on_grid(c.row, c.col) || !on_grid(c.row_end, c.col_end)) begin
          a.status = ST_COORD;
        end else if (c.row > c.row_end || c.col > c.col_end) begin
          a.status = ST_ORDER;
        end else if (!printable(c.symbol)) begin
          a.status = ST_SYMBOL;
        end else begin
          // Top and bottom edges, then left and right edges. A single row,
          // column or cell simply writes the same cells more than once.
          for (i = c.col; i <= c.col_end; i++) begin
            shadow_grid[cell_index(c.row, i)] = c.symbol;
            shadow_grid[cell_index(c.row_end, i)] = c.symbol;
          end
          for (i = c.row; i <= c.row_end; i++) begin
            shadow_grid[cell_index(i, c.col)] = c.symbol;
            shadow_grid[cell_index(i, c.col_end)] = c.symbol;
          end
        end
      end
      default: begin
        // Read: the symbol field plays no part and nothing is written.
        if (!on_grid(c.row, c.col)) begin
          a.status = ST_COORD;
        end else begin
          a.cell_value = shadow_grid[cell_index(c.row, c.col)];
        end
      end
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting. Every mismatch prints one line and is counted.
  // ---------------------------------------------------------------------------
  task automatic report(string what);
    $display("mismatch at %0t ns: %s", $time, what);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor and checker. Everything is sampled at the rising edge; inputs
  // only move on the falling edge, so the values seen here are settled.
  // Prediction runs before the check, although the block's latency means the
  // result leaving on this edge always belongs to an older item.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    grid_cmd_t    cmd;
    grid_answer_t want;
    if (rst_n) begin
      // The blank symbol only changes while no command is in flight.
      if (cfg_we) begin
        shadow_blank = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        cmd.op      = in_operation;
        cmd.row     = in_row;
        cmd.col     = in_col;
        cmd.row_end = in_row_end;
        cmd.col_end = in_col_end;
        cmd.symbol  = in_symbol;
        answers_q.push_back(apply_cmd(cmd));
      end
      if (out_valid && !out_stall) begin
        if (answers_q.size() == 0) begin
          report($sformatf("unexpected result status %0d cell_value %0d",
                           out_status, out_cell_value));
        end else begin
          want = answers_q.pop_front();
          if (out_status !== want.status) begin
            report($sformatf("status %0d, expected %0d", out_status, want.status));
          end
          if (out_cell_value !== want.cell_value) begin
            report($sformatf("cell_value %0d, expected %0d",
                             out_cell_value, want.cell_value));
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Result side: stall for random stretches, changed only on the falling edge.
  always @(negedge clk) begin
    if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
    end
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side. All tasks start and end on a falling edge.
  // ---------------------------------------------------------------------------

  // Sends one item and returns once it has been accepted. Valid stays high
  // after acceptance so back-to-back items need no extra assignment; it is
  // lowered by the next gap or by wait_idle.
  task automatic send_cmd(logic [1:0] op, logic [7:0] row, logic [7:0] col,
                          logic [7:0] row_end, logic [7:0] col_end,
                          logic [7:0] symbol);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_operation = op;
    in_row       = row;
    in_col       = col;
    in_row_end   = row_end;
    in_col_end   = col_end;
    in_symbol    = symbol;
    do begin
      @(posedge clk);
    end while (in_stall);
    @(negedge clk);
  endtask

  // Drops valid and waits until every predicted answer has come back. Every
  // command gives exactly one result, so the block is idle after that.
  task automatic wait_idle();
    in_valid = 1'b0;
    while (answers_q.size() != 0) @(negedge clk);
  endtask

  // Writes the blank symbol register between phases.
  task automatic set_blank(logic [7:0] value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Writes both ends of the symbol range at opposite grid corners and reads all
  // four corners; untouched cells still hold the reset blank.
  task automatic test_cell_edges();
    send_cmd(OP_PUT,  8'd1,  8'd1,   8'd0, 8'd0, SYM_LOW);
    send_cmd(OP_PUT,  8'd32, 8'd128, 8'd0, 8'd0, SYM_HIGH);
    send_cmd(OP_READ, 8'd1,  8'd1,   8'd0, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'd32, 8'd128, 8'd0, 8'd0, 8'd255);
    send_cmd(OP_READ, 8'd32, 8'd1,   8'd0, 8'd0, 8'd0);
    send_cmd(OP_READ, 8'd1,  8'd128, 8'd0, 8'd0, 8'd0);
  endtask

  // Zero coordinates and coordinates just past the grid, on every operation.
  task automatic test_bad_coords();
    send_cmd(OP_PUT,   8'd0,   8'd1,   8'd0,  8'd0,   8'd65);
    send_cmd(OP_ERASE, 8'd1,   8'd0,   8'd0,  8'd0,   8'd0);
    send_cmd(OP_READ,  8'd33,  8'd128, 8'd0,  8'd0,   8'd0);
    send_cmd(OP_READ,  8'd255, 8'd129, 8'd0,  8'd0,   8'd0);
    send_cmd(OP_DRAW,  8'd1,   8'd1,   8'd32, 8'd255, 8'd66);
  endtask

  // Symbols just outside the printable range and at the ends of the byte.
  task automatic test_bad_symbols();
    send_cmd(OP_PUT,  8'd2, 8'd2, 8'd0, 8'd0, 8'd32);
    send_cmd(OP_PUT,  8'd2, 8'd2, 8'd0, 8'd0, 8'd127);
    send_cmd(OP_DRAW, 8'd3, 8'd3, 8'd4, 8'd4, 8'd0);
    send_cmd(OP_DRAW, 8'd3, 8'd3, 8'd4, 8'd4, 8'd255);
  endtask

  // Single cell, single row, single column and whole-grid outlines, plus the
  // precedence of the coordinate check over corner order over symbol.
  task automatic test_rectangles();
    send_cmd(OP_DRAW, 8'd5, 8'd5,  8'd5,  8'd5,   8'd42);
    send_cmd(OP_DRAW, 8'd6, 8'd1,  8'd6,  8'd128, 8'd45);
    send_cmd(OP_DRAW, 8'd1, 8'd10, 8'd32, 8'd10,  8'd124);
    send_cmd(OP_DRAW, 8'd1, 8'd1,  8'd32, 8'd128, 8'd35);
    send_cmd(OP_DRAW, 8'd9, 8'd9,  8'd8,  8'd9,   8'd0);
    send_cmd(OP_DRAW, 8'd0, 8'd9,  8'd8,  8'd9,   8'd0);
    send_cmd(OP_READ, 8'd6, 8'd64, 8'd0,  8'd0,   8'd0);
    send_cmd(OP_READ, 8'd5, 8'd5,  8'd0,  8'd0,   8'd0);
  endtask

  // A new blank symbol applies to later erases only; stored cells keep theirs.
  task automatic test_erase_blank();
    set_blank(8'd0);
    send_cmd(OP_ERASE, 8'd1,  8'd1,   8'd0, 8'd0, 8'd0);
    send_cmd(OP_READ,  8'd1,  8'd1,   8'd0, 8'd0, 8'd0);
    send_cmd(OP_READ,  8'd32, 8'd128, 8'd0, 8'd0, 8'd0);
    send_cmd(OP_ERASE, 8'd0,  8'd0,   8'd0, 8'd0, 8'd0);
  endtask

  // ---------------------------------------------------------------------------
  // Random commands
  // ---------------------------------------------------------------------------

  // Mostly a coordinate inside the given span, sometimes any byte at all.
  function automatic logic [7:0] pick_coord(int span);
    if ($urandom_range(0, 99) < 8) begin
      return 8'($urandom_range(0, 255));
    end
    return 8'($urandom_range(1, span));
  endfunction

  task automatic random_cmd();
    logic [1:0] op;
    logic [7:0] row, col, row_end, col_end, symbol, held;
    bit         hot;
    int         pick, h, w;
    // Half the commands land in a small corner so reads hit recent writes.
    hot  = ($urandom_range(0, 1) == 1);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      op = OP_READ;
    end else if (pick < 60) begin
      op = OP_PUT;
    end else if (pick < 75) begin
      op = OP_ERASE;
    end else begin
      op = OP_DRAW;
    end
    row = pick_coord(hot ? 4 : ROWS);
    col = pick_coord(hot ? 8 : COLS);
    // Rectangles are small except for a few that may span the grid.
    if ($urandom_range(0, 99) < 3) begin
      h = $urandom_range(0, ROWS - 1);
      w = $urandom_range(0, COLS - 1);
    end else begin
      h = $urandom_range(0, 3);
      w = $urandom_range(0, 5);
    end
    row_end = 8'(row + h);
    col_end = 8'(col + w);
    if ($urandom_range(0, 9) == 0) begin
      row_end = 8'($urandom_range(0, 255));
      col_end = 8'($urandom_range(0, 255));
    end
    // Now and then swap a corner pair so the order check gets exercised.
    if ($urandom_range(0, 19) == 0) begin
      held = row;
      row = row_end;
      row_end = held;
    end else if ($urandom_range(0, 19) == 0) begin
      held = col;
      col = col_end;
      col_end = held;
    end
    if ($urandom_range(0, 9) == 0) begin
      symbol = 8'($urandom_range(0, 255));
    end else begin
      symbol = 8'($urandom_range(SYM_LOW, SYM_HIGH));
    end
    send_cmd(op, row, col, row_end, col_end, symbol);
  endtask

  // One random phase under a given blank symbol, optionally without idling.
  task automatic test_random_mix(int count, logic [7:0] blank, bit no_gaps);
    set_blank(blank);
    calm = no_gaps;
    repeat (count) random_cmd();
    calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    for (i = 0; i < ROWS * COLS; i++) begin
      shadow_grid[i] = EMPTY_RESET;
    end
    shadow_blank = EMPTY_RESET;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_PUT;
    in_row       = 8'd0;
    in_col       = 8'd0;
    in_row_end   = 8'd0;
    in_col_end   = 8'd0;
    in_symbol    = 8'd0;
    cfg_we       = 1'b0;
    cfg_wdata    = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // The first phase runs with the reset blank; the block stalls the input
    // until its clearing sweep is done.
    test_cell_edges();
    test_bad_coords();
    test_bad_symbols();
    test_rectangles();
    test_erase_blank();

    // Random phases cover both extremes of the blank register, the reset
    // value and a random one; one phase runs with no idling at all.
    test_random_mix(460, 8'd255, 1'b0);
    test_random_mix(460, 8'($urandom_range(0, 255)), 1'b1);
    test_random_mix(460, 8'd0, 1'b0);
    test_random_mix(460, EMPTY_RESET, 1'b0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
